// ----- hw/rtl/qmv_pkg.sv -----
`default_nettype none
package qmv_pkg;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int ACT_W   = 16;
	localparam int SCALE_W = 16;
	localparam int ZERO_W  = 8;
	localparam int NIB_W   = 4;
	localparam int VAL_W   = 64;
	localparam int COLS_W  = 13;

	// Datapath widths: (q*16 - zero) is Q.4, times scale is Q.16, times act is Q.24
	localparam int DIFF_W  = 13;
	localparam int DEQ_W   = DIFF_W + SCALE_W;
	localparam int PROD_W  = DEQ_W + ACT_W;

	// Configuration port
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_WEIGHT_FORMAT = 2'd0;
	localparam logic [IDX_W-1:0] REG_OUTPUT_MODE   = 2'd1;
	localparam logic [IDX_W-1:0] REG_NUM_COLS      = 2'd2;

	localparam logic [COLS_W-1:0] NUM_COLS_RESET = 13'd4096;
	localparam int MAX_COLS_DEF = 4096;

	// Weight format and output mode codes
	localparam logic FMT_INT8  = 1'b0;
	localparam logic FMT_INT4  = 1'b1;
	localparam logic MODE_DOT  = 1'b0;
	localparam logic MODE_DEQ  = 1'b1;

	typedef struct packed {
		logic weight_format;
		logic output_mode;
		logic [COLS_W-1:0] num_cols;
	} qmv_cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic deq_en;
		logic mac_en;
		logic nib_sel;
	} qmv_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic row_end;
		logic out_free;
	} qmv_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/qmv_regs.sv -----
`default_nettype none
module qmv_regs import qmv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output qmv_cfg_t               cfg
);

	logic             wr_en;
	logic [IDX_W-1:0] idx;
	qmv_cfg_t         cfg_q;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_format <= FMT_INT8;
			cfg_q.output_mode   <= MODE_DOT;
			cfg_q.num_cols      <= NUM_COLS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_WEIGHT_FORMAT: cfg_q.weight_format <= pwdata[0];
				REG_OUTPUT_MODE:   cfg_q.output_mode   <= pwdata[0];
				REG_NUM_COLS:      cfg_q.num_cols      <= pwdata[COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_WEIGHT_FORMAT: prdata = {{(APB_DW-1){1'b0}}, cfg_q.weight_format};
			REG_OUTPUT_MODE:   prdata = {{(APB_DW-1){1'b0}}, cfg_q.output_mode};
			REG_NUM_COLS:      prdata = {{(APB_DW-COLS_W){1'b0}}, cfg_q.num_cols};
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/qmv_ctrl.sv -----
`default_nettype none
module qmv_ctrl import qmv_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire qmv_cfg_t    cfg,
	input  wire qmv_status_t status,
	output qmv_cmd_t   cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEQ  = 2'd1;
	localparam logic [1:0] S_MAC  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       nib_q, nib_d;
	logic       need_out;
	logic       mac_go;

	assign in_stall = (state_q != S_IDLE);
	assign need_out = (cfg.output_mode == MODE_DEQ) | status.row_end;
	assign mac_go   = (state_q == S_MAC) & (!need_out | status.out_free);

	assign cmd.capture = (state_q == S_IDLE) & in_valid;
	assign cmd.deq_en  = (state_q == S_DEQ);
	assign cmd.mac_en  = mac_go;
	assign cmd.nib_sel = nib_q;

	// Sequence: take byte, dequantize, multiply-accumulate, repeat for low nibble in 4-bit format unless the row ended
	always_comb begin
		state_d = state_q;
		nib_d   = nib_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEQ;
					nib_d   = 1'b0;
				end
			end
			S_DEQ: state_d = S_MAC;
			S_MAC: begin
				if (mac_go) begin
					if (cfg.weight_format == FMT_INT4 && !nib_q && !status.row_end) begin
						state_d = S_DEQ;
						nib_d   = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nib_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			nib_q   <= nib_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/qmv_dp.sv -----
`default_nettype none
module qmv_dp import qmv_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic        [BYTE_W-1:0]   weight_byte,
	input  wire logic signed [ACT_W-1:0]    act_first,
	input  wire logic signed [ACT_W-1:0]    act_second,
	input  wire logic signed [SCALE_W-1:0]  row_scale,
	input  wire logic signed [ZERO_W-1:0]   row_zero,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed      [VAL_W-1:0]    value,
	output logic                            last_of_row,
	input  wire qmv_cfg_t                   cfg,
	input  wire qmv_cmd_t                   cmd,
	output qmv_status_t                     status
);

	localparam int COLS_MAX_VAL = (1 << COLS_W) - 1;
	localparam int CAP = (MAX_COLS > COLS_MAX_VAL) ? COLS_MAX_VAL : MAX_COLS;
	localparam logic [COLS_W-1:0] CAP_W = COLS_W'(CAP);
	localparam logic [COLS_W-1:0] ONE_COL = COLS_W'(1);

	logic        [BYTE_W-1:0]  byte_q;
	logic signed [ACT_W-1:0]   act1_q, act2_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic signed [ZERO_W-1:0]  zero_q;

	logic signed [NIB_W-1:0]   nib;
	logic signed [DIFF_W-1:0]  q_ext, zero_ext, diff;
	logic signed [DEQ_W-1:0]   deq_d, deq_q;
	logic signed [ACT_W-1:0]   act_sel;
	logic signed [PROD_W-1:0]  prod;
	logic        [VAL_W-1:0]   row_sum_q, sum_new;
	logic        [COLS_W-1:0]  col_q, col_inc, eff_cols;
	logic                      row_end, emit, is_deq;
	logic                      out_valid_q, last_q;
	logic signed [VAL_W-1:0]   value_q;

	// Hold the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q  <= weight_byte;
			act1_q  <= act_first;
			act2_q  <= act_second;
			scale_q <= row_scale;
			zero_q  <= row_zero;
		end
	end

	// Dequantize the selected weight: (q*16 - zero) * scale, zero used only in 4-bit format
	assign nib      = cmd.nib_sel ? byte_q[NIB_W-1:0] : byte_q[BYTE_W-1:NIB_W];
	assign q_ext    = (cfg.weight_format == FMT_INT4) ? DIFF_W'(nib)
	                                                  : DIFF_W'(signed'(byte_q));
	assign zero_ext = (cfg.weight_format == FMT_INT4) ? DIFF_W'(zero_q) : '0;
	assign diff     = (q_ext <<< 4) - zero_ext;
	assign deq_d    = diff * scale_q;

	always_ff @(posedge clk) begin
		if (cmd.deq_en) deq_q <= deq_d;
	end

	// Multiply by activation and accumulate
	assign act_sel = cmd.nib_sel ? act2_q : act1_q;
	assign prod    = deq_q * act_sel;
	assign sum_new = row_sum_q + VAL_W'(prod);

	// Clamp the column limit: zero acts as one, cap at MAX_COLS
	always_comb begin
		if (cfg.num_cols == '0)        eff_cols = ONE_COL;
		else if (cfg.num_cols > CAP_W) eff_cols = CAP_W;
		else                           eff_cols = cfg.num_cols;
	end

	assign col_inc = col_q + ONE_COL;
	assign row_end = (col_inc >= eff_cols);
	assign is_deq  = (cfg.output_mode == MODE_DEQ);
	assign emit    = cmd.mac_en & (is_deq | row_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_sum_q <= '0;
		end else if (cmd.mac_en) begin
			col_q     <= row_end ? '0 : col_inc;
			row_sum_q <= row_end ? '0 : sum_new;
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q <= is_deq ? VAL_W'(deq_q) : signed'(sum_new);
			last_q  <= is_deq ? row_end : 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign value           = value_q;
	assign last_of_row     = last_q;
	assign status.row_end  = row_end;
	assign status.out_free = !out_valid_q | !out_stall;

endmodule
`default_nettype wire

// ----- hw/rtl/quantized_weight_matvec.sv -----
`default_nettype none
// A result is registered in the dequantize register, then in the output register, after
// its byte is accepted (a low nibble result the same way after the high nibble one), later if the output stalls.
// A new byte is taken only once the previous one is through the accept / dequantize /
// multiply-accumulate sequence, run once in 8-bit format and per nibble in 4-bit format.
// Reset (arst_n, async low): idle, column count and row sum zero, registers to defaults.
module quantized_weight_matvec import qmv_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic        [APB_AW-1:0]  paddr,
	input  wire logic        [APB_DW-1:0]  pwdata,
	output logic             [APB_DW-1:0]  prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic        [BYTE_W-1:0]  weight_byte,
	input  wire logic signed [ACT_W-1:0]   act_first,
	input  wire logic signed [ACT_W-1:0]   act_second,
	input  wire logic signed [SCALE_W-1:0] row_scale,
	input  wire logic signed [ZERO_W-1:0]  row_zero,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed      [VAL_W-1:0]   value,
	output logic                           last_of_row
);

	qmv_cfg_t    cfg;
	qmv_cmd_t    cmd;
	qmv_status_t status;

	qmv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cfg      (cfg),
		.status   (status),
		.cmd      (cmd)
	);

	qmv_dp #(
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.weight_byte (weight_byte),
		.act_first   (act_first),
		.act_second  (act_second),
		.row_scale   (row_scale),
		.row_zero    (row_zero),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.last_of_row (last_of_row),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status)
	);

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
package qmv_check_pkg;
	import qmv_pkg::*;

	// One packed weight byte with its activations and row parameters
	typedef struct {
		logic        [BYTE_W-1:0]  wbyte;
		logic signed [ACT_W-1:0]   act_a;
		logic signed [ACT_W-1:0]   act_b;
		logic signed [SCALE_W-1:0] scale;
		logic signed [ZERO_W-1:0]  zero;
	} weight_item_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             last;
	} row_result_t;

	// Tracks register settings and row state, predicts dot/dequant results
	class matvec_scoreboard;
		logic              fmt;
		logic              mode;
		logic [COLS_W-1:0] ncols;
		int unsigned       col_cnt;
		logic [VAL_W-1:0]  row_acc;
		int unsigned       rows_done;
		row_result_t       expected_q[$];

		function new();
			fmt = FMT_INT8;
			mode = MODE_DOT;
			ncols = NUM_COLS_RESET;
			col_cnt = 0;
			row_acc = '0;
			rows_done = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [APB_DW-1:0] data);
			case (idx)
				REG_WEIGHT_FORMAT: fmt = data[0];
				REG_OUTPUT_MODE:   mode = data[0];
				REG_NUM_COLS:      ncols = data[COLS_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Zero acts as one, anything above the maximum is clipped
		function int unsigned eff_cols();
			int unsigned n;
			n = ncols;
			if (n == 0) n = 1;
			if (n > MAX_COLS_DEF) n = MAX_COLS_DEF;
			return n;
		endfunction

		// Accumulate one weight; return 1 when it closes the row
		function bit take_weight(longint q, longint zero, longint scale, longint act);
			longint deq;
			bit     ended;
			deq = (q * 16 - zero) * scale;
			row_acc = row_acc + deq * act;
			col_cnt++;
			ended = (col_cnt >= eff_cols());
			if (mode == MODE_DEQ) expected_q.push_back('{deq, ended});
			if (ended) begin
				if (mode == MODE_DOT) expected_q.push_back('{row_acc, 1'b1});
				row_acc = '0;
				col_cnt = 0;
				rows_done++;
			end
			return ended;
		endfunction

		function void note_input(weight_item_t it);
			logic signed [BYTE_W-1:0] q8;
			logic signed [NIB_W-1:0]  hi_n;
			logic signed [NIB_W-1:0]  lo_n;
			q8 = it.wbyte;
			hi_n = it.wbyte[7:4];
			lo_n = it.wbyte[3:0];
			if (fmt == FMT_INT8) begin
				void'(take_weight(q8, 0, it.scale, it.act_a));
			end else if (!take_weight(hi_n, it.zero, it.scale, it.act_a)) begin
				// low nibble only when the high one did not close the row
				void'(take_weight(lo_n, it.zero, it.scale, it.act_b));
			end
		endfunction

		// Compare against the oldest expectation; empty string on match
		function string check_result(logic [VAL_W-1:0] v, logic last);
			row_result_t want;
			string       msg;
			msg = "";
			if (expected_q.size() == 0)
				return $sformatf("unexpected result value=%0d last_of_row=%0b",
					$signed(v), last);
			want = expected_q.pop_front();
			if (v !== want.value)
				msg = $sformatf("value got %0d want %0d", $signed(v), $signed(want.value));
			if (last !== want.last)
				msg = {msg, $sformatf(" last_of_row got %0b want %0b", last, want.last)};
			return msg;
		endfunction
	endclass

endpackage

module tb_top;
	import qmv_pkg::*;
	import qmv_check_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TAIL  = 16;
	localparam int HOLD_LEN     = 300;
	localparam int RAND_PHASES  = 32;
	localparam int PHASE_ITEMS  = 50;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic        [APB_AW-1:0]  paddr;
	logic        [APB_DW-1:0]  pwdata;
	logic        [APB_DW-1:0]  prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_stall;
	logic        [BYTE_W-1:0]  weight_byte;
	logic signed [ACT_W-1:0]   act_first;
	logic signed [ACT_W-1:0]   act_second;
	logic signed [SCALE_W-1:0] row_scale;
	logic signed [ZERO_W-1:0]  row_zero;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [VAL_W-1:0]   value;
	logic                      last_of_row;

	matvec_scoreboard sb;
	int unsigned cycle_cnt = 0;
	int unsigned mismatches = 0;
	int unsigned items_in = 0;
	int unsigned results_out = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_requests = 0;
	logic signed [SCALE_W-1:0] cur_scale = 16'sd4096;
	logic signed [ZERO_W-1:0]  cur_zero = '0;

	quantized_weight_matvec i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.weight_byte (weight_byte),
		.act_first   (act_first),
		.act_second  (act_second),
		.row_scale   (row_scale),
		.row_zero    (row_zero),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.last_of_row (last_of_row)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0d] mismatch: %s", cycle_cnt, msg);
	endtask

	// Sample both channels at the rising edge
	always @(posedge clk) begin : monitor
		string msg;
		weight_item_t seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_out++;
				msg = sb.check_result(value, last_of_row);
				if (msg != "") report_mismatch(msg);
			end
			if (in_valid && !in_stall) begin
				seen.wbyte = weight_byte;
				seen.act_a = act_first;
				seen.act_b = act_second;
				seen.scale = row_scale;
				seen.zero = row_zero;
				sb.note_input(seen);
				items_in++;
			end
		end
	end

	// Receiver: random stalls plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		int unsigned served;
		hold_left = 0;
		served = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	function automatic logic [15:0] pick16();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic weight_item_t mk(input logic [7:0] b, input int a1, input int a2,
			input int s, input int z);
		weight_item_t it;
		it.wbyte = b;
		it.act_a = a1[15:0];
		it.act_b = a2[15:0];
		it.scale = s[15:0];
		it.zero = z[7:0];
		return it;
	endfunction

	// Keep scale and zero steady over a row, with occasional mid-row noise
	function automatic weight_item_t next_random_item();
		weight_item_t it;
		if ((sb.col_cnt == 0 && $urandom_range(9) != 0) || $urandom_range(15) == 0) begin
			cur_scale = pick16();
			case ($urandom_range(7))
				0: cur_zero = 8'h80;
				1: cur_zero = 8'h7F;
				default: cur_zero = 8'($urandom);
			endcase
		end
		it.wbyte = 8'($urandom_range(255));
		it.act_a = pick16();
		it.act_b = pick16();
		it.scale = cur_scale;
		it.zero = cur_zero;
		return it;
	endfunction

	// Offer one transaction; return at the falling edge after it is taken
	task automatic send_item(input weight_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		weight_byte <= it.wbyte;
		act_first <= it.act_a;
		act_second <= it.act_b;
		row_scale <= it.scale;
		row_zero <= it.zero;
		do @(posedge clk); while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);
	endtask

	task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic fmt, input logic mode, input int unsigned ncols);
		settle();
		apb_write(REG_WEIGHT_FORMAT, APB_DW'(fmt));
		apb_write(REG_OUTPUT_MODE, APB_DW'(mode));
		apb_write(REG_NUM_COLS, APB_DW'(ncols));
	endtask

	function automatic int unsigned random_cols();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 8) return MAX_COLS_DEF;
		if (r < 10) return $urandom_range(MAX_COLS_DEF + 1, 8191);
		if (r < 22) return $urandom_range(17, 200);
		return $urandom_range(1, 16);
	endfunction

	initial begin : stimulus
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		weight_byte = '0;
		act_first = '0;
		act_second = '0;
		row_scale = '0;
		row_zero = '0;
		sb = new();

		// Hold reset, release on a falling edge
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: partial int8 dot row with extreme values
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_item(mk(8'h7F, 32767, 0, 32767, 0));
		send_item(mk(8'h80, -32768, 32767, -32768, -128));

		// Lower column count below the count taken: row ends at the next weight
		configure(FMT_INT8, MODE_DOT, 1);
		send_item(mk(8'h01, 256, -1, 4096, 127));

		// Zero column count behaves as one
		configure(FMT_INT8, MODE_DOT, 0);
		send_item(mk(8'h00, 32767, 32767, 32767, 127));
		send_item(mk(8'hFF, -32768, -32768, 32767, 0));

		// Int4 dequant with odd column count: spare low nibble skipped
		rx_stall_pct = 8;
		configure(FMT_INT4, MODE_DEQ, 3);
		send_item(mk(8'h88, 100, -100, 32767, -128));
		send_item(mk(8'h77, -32768, 32767, -32768, 127));
		send_item(mk(8'hF0, 32767, -32768, -32768, -128));
		send_item(mk(8'h0F, -1, 1, 32767, 127));

		configure(FMT_INT4, MODE_DOT, 2);
		send_item(mk(8'h7F, 32767, -32768, 32767, -128));
		send_item(mk(8'h80, -32768, -32768, -32768, 127));

		// Switch mode mid-row: dot result still covers the whole row
		configure(FMT_INT4, MODE_DEQ, 5);
		send_item(mk(8'h12, 512, -512, 4096, 16));
		configure(FMT_INT4, MODE_DOT, 5);
		send_item(mk(8'h34, -256, 1024, 4096, 16));
		send_item(mk(8'h56, 300, -300, 4096, 16));

		// Column count above the maximum is clipped, then lowered mid-row
		configure(FMT_INT8, MODE_DEQ, 8191);
		send_item(mk(8'h81, 1, 2, 2048, 0));
		send_item(mk(8'h7E, 3, 4, -2048, 0));
		send_item(mk(8'h40, 5, 6, 1, 0));
		configure(FMT_INT8, MODE_DEQ, 2);
		send_item(mk(8'hC0, 7, 8, -1, 0));

		// Random phases over settings and idle/stall mixes
		for (int p = 0; p < RAND_PHASES; p++) begin
			configure(1'($urandom_range(1)), 1'($urandom_range(1)), random_cols());
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
				default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
			endcase
			// Long receiver hold-off while the sender keeps offering
			if (p == 4 || p == 20) hold_requests++;
			for (int n = 0; n < PHASE_ITEMS; n++) send_item(next_random_item());
			// Mid-run pause until every expected result has arrived
			if (p == 10) settle();
		end

		settle();
		if (sb.pending() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
		$display("covered %0d input transactions, %0d results, %0d completed rows",
			items_in, results_out, sb.rows_done);
		$display("int8/int4 x dot/dequant, column counts 0..8191, mixed idling, %0d-cycle hold-offs",
			HOLD_LEN);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/qmv_pkg.sv
hw/rtl/qmv_regs.sv
hw/rtl/qmv_ctrl.sv
hw/rtl/qmv_dp.sv
hw/rtl/quantized_weight_matvec.sv
verif/tb_top.sv
